FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Every macro samples on clk_i and is quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define MPST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mpst assertion failed");

// When pre holds, post must hold in the same cycle.
`define MPST_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mpst assertion failed");

// When pre holds, post must hold in the next cycle.
`define MPST_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mpst assertion failed");

`endif

FILE: hw/rtl/mpst_pkg.sv
package mpst_pkg;

  // Record geometry.
  localparam int MAX_SAMPLES = 2048;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int E_W         = 42;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SNR_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_DIV = 2'd2;

  // Input request: eight channel samples and the record end mark.
  typedef struct packed {
    logic signed [15:0] sample_h1;
    logic signed [15:0] sample_v1;
    logic signed [15:0] sample_h2;
    logic signed [15:0] sample_v2;
    logic signed [15:0] sample_h3;
    logic signed [15:0] sample_v3;
    logic signed [15:0] sample_h4;
    logic signed [15:0] sample_v4;
    logic               last_sample;
  } in_t;

  // Result request.
  typedef struct packed {
    logic        is_pulse;
    logic [15:0] h_snr_avg;
    logic [15:0] h_peak_avg;
    logic [15:0] v_peak_avg;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pass_start;
    logic pass_rd;
    logic snr_first;
    logic snr_sq;
    logic snr_mul;
    logic snr_chk;
    logic div_step;
    logic sqrt_step;
    logic step_clr;
    logic snr_store;
    logic snr_next;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_end;
    logic pipe_busy;
    logic special;
    logic div_last;
    logic sqrt_last;
    logic sel_last;
    logic out_busy;
  } sts_t;

  // Exact floor(x / 3) for x below 3 * 2^16, by a reciprocal multiply.
  function automatic logic [15:0] div3(input logic [17:0] x);
    logic [37:0] p;
    p = 38'(x) * 38'd349526;
    return p[35:20];
  endfunction

endpackage

FILE: hw/rtl/mpst_ctrl.sv
module mpst_ctrl import mpst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PASS  = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_STORE = 4'd9;
  localparam logic [3:0] S_FINAL = 4'd10;

  logic [3:0] state_q, state_d;

  // Sequencing of load, energy pass and per-channel SNR evaluation.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.pass_start = 1'b1;
            state_d          = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (sts_i.pass_end) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.pass_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.snr_first = 1'b1;
          state_d         = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.snr_sq = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.snr_mul = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        cmd_o.snr_chk  = 1'b1;
        cmd_o.step_clr = 1'b1;
        state_d        = S_DEC;
      end
      S_DEC: begin
        state_d = sts_i.special ? S_STORE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.step_clr = 1'b1;
          state_d        = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.sqrt_last) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.snr_store = 1'b1;
        if (sts_i.sel_last) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.snr_next = 1'b1;
          state_d        = S_SQ;
        end
      end
      S_FINAL: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/mpst_dp.sv
module mpst_dp import mpst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  in_t                  in_data_i,
  input  logic                 out_ready_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  output out_t                 out_data_o
);

  // Configuration registers.
  logic [15:0] thr_q;
  logic [9:0]  ghw_q;
  logic [11:0] div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd384;
      ghw_q <= 10'd50;
      div_q <= 12'd1400;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SNR_THR: thr_q <= cfg_data_i;
        REG_GUARD:   ghw_q <= cfg_data_i[9:0];
        REG_RMS_DIV: div_q <= cfg_data_i[11:0];
        default:     ;
      endcase
    end
  end

  // Channel magnitudes of the incoming request, channels 0 to 5.
  logic [15:0] smp [6];
  logic [15:0] mag [6];

  assign smp[0] = in_data_i.sample_h1;
  assign smp[1] = in_data_i.sample_v1;
  assign smp[2] = in_data_i.sample_h2;
  assign smp[3] = in_data_i.sample_v2;
  assign smp[4] = in_data_i.sample_h3;
  assign smp[5] = in_data_i.sample_v3;

  always_comb begin
    for (int c = 0; c < 6; c++) begin
      mag[c] = smp[c][15] ? (~smp[c] + 16'd1) : smp[c];
    end
  end

  // Sample count, peaks and horizontal peak positions.
  logic [CNT_W-1:0]  cnt_q;
  logic [15:0]       peak_q [6];
  logic [ADDR_W-1:0] pos_q [3];
  logic              store_ok;
  logic [ADDR_W-1:0] wr_addr;

  assign store_ok = (cnt_q < CNT_W'(MAX_SAMPLES));
  assign wr_addr  = cnt_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int c = 0; c < 6; c++) peak_q[c] <= '0;
      for (int h = 0; h < 3; h++) pos_q[h] <= '0;
    end else if (cmd_i.finish) begin
      cnt_q <= '0;
      for (int c = 0; c < 6; c++) peak_q[c] <= '0;
      for (int h = 0; h < 3; h++) pos_q[h] <= '0;
    end else if (cmd_i.load && store_ok) begin
      cnt_q <= cnt_q + CNT_W'(1);
      for (int c = 0; c < 6; c++) begin
        if (mag[c] > peak_q[c]) peak_q[c] <= mag[c];
      end
      for (int h = 0; h < 3; h++) begin
        if (mag[2*h] > peak_q[2*h]) pos_q[h] <= wr_addr;
      end
    end
  end

  // Record memory of the horizontal channels 0, 2 and 4.
  logic [47:0]       mem [MAX_SAMPLES];
  logic [47:0]       rd_data_q;
  logic [CNT_W-1:0]  rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      mem[wr_addr] <= {smp[4], smp[2], smp[0]};
    end
    if (cmd_i.pass_rd) begin
      rd_data_q <= mem[rd_addr_q[ADDR_W-1:0]];
    end
  end

  // Read address and pipeline valid flags of the energy pass.
  logic              rd_v1_q, sq_v_q;
  logic [ADDR_W-1:0] rd_idx1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_v1_q   <= 1'b0;
      sq_v_q    <= 1'b0;
    end else begin
      if (cmd_i.pass_start) begin
        rd_addr_q <= '0;
      end else if (cmd_i.pass_rd) begin
        rd_addr_q <= rd_addr_q + CNT_W'(1);
      end
      rd_v1_q <= cmd_i.pass_rd;
      sq_v_q  <= rd_v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx1_q <= rd_addr_q[ADDR_W-1:0];
  end

  // Square each sample and mark those outside the guard window.
  logic [31:0]       sq_q [3];
  logic              keep_q [3];
  logic signed [15:0] rv [3];
  logic [ADDR_W-1:0] gap [3];

  always_comb begin
    for (int h = 0; h < 3; h++) begin
      rv[h]  = rd_data_q[16*h +: 16];
      gap[h] = (rd_idx1_q > pos_q[h]) ? (rd_idx1_q - pos_q[h]) : (pos_q[h] - rd_idx1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int h = 0; h < 3; h++) begin
      sq_q[h]   <= 32'(rv[h] * rv[h]);
      keep_q[h] <= (16'(gap[h]) > 16'(ghw_q));
    end
  end

  // Saturating noise energy accumulators.
  logic [E_W-1:0] energy_q [3];
  logic [E_W:0]   esum [3];

  always_comb begin
    for (int h = 0; h < 3; h++) begin
      esum[h] = {1'b0, energy_q[h]} + (E_W+1)'(sq_q[h]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int h = 0; h < 3; h++) begin
      if (cmd_i.pass_start) begin
        energy_q[h] <= '0;
      end else if (sq_v_q && keep_q[h]) begin
        energy_q[h] <= esum[h][E_W] ? {E_W{1'b1}} : esum[h][E_W-1:0];
      end
    end
  end

  // Channel select and step counter of the SNR unit.
  logic [1:0] sel_q;
  logic [4:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      step_q <= '0;
    end else begin
      if (cmd_i.snr_first) begin
        sel_q <= '0;
      end else if (cmd_i.snr_next) begin
        sel_q <= sel_q + 2'd1;
      end
      if (cmd_i.step_clr) begin
        step_q <= '0;
      end else if (cmd_i.div_step || cmd_i.sqrt_step) begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  // SNR unit: peak^2 * divisor * 2^16 / energy, then integer square root.
  logic [15:0] pk_sel;
  logic [31:0] pk_sq_q;
  logic [43:0] num_q;
  logic [E_W-1:0] e_q;
  logic        zero_q, sat_q;
  logic [E_W-1:0] rem_q;
  logic [31:0] dsh_q;
  logic [17:0] srem_q;
  logic [15:0] root_q;
  logic [15:0] snr_q [3];
  logic [E_W:0] rem_sh;
  logic        div_ge;
  logic [19:0] srem_sh;
  logic [19:0] trial;
  logic        sqrt_ge;

  assign pk_sel  = peak_q[{sel_q, 1'b0}];
  assign rem_sh  = {rem_q, dsh_q[31]};
  assign div_ge  = (rem_sh >= {1'b0, e_q});
  assign srem_sh = {srem_q, dsh_q[31:30]};
  assign trial   = 20'({root_q, 2'b01});
  assign sqrt_ge = (srem_sh >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.snr_sq) begin
      pk_sq_q <= 32'(pk_sel) * 32'(pk_sel);
    end
    if (cmd_i.snr_mul) begin
      num_q <= 44'(pk_sq_q) * 44'(div_q);
      e_q   <= energy_q[sel_q];
    end
    if (cmd_i.snr_chk) begin
      zero_q <= (pk_sel == 16'd0) || (div_q == 12'd0);
      sat_q  <= (e_q == '0) || ({14'd0, num_q} >= {e_q, 16'd0});
      rem_q  <= E_W'(num_q[43:16]);
      dsh_q  <= {num_q[15:0], 16'd0};
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? E_W'(rem_sh - {1'b0, e_q}) : rem_sh[E_W-1:0];
      dsh_q <= {dsh_q[30:0], div_ge};
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sqrt_ge ? 18'(srem_sh - trial) : srem_sh[17:0];
      root_q <= {root_q[14:0], sqrt_ge};
      dsh_q  <= {dsh_q[29:0], 2'b00};
    end
    if (cmd_i.snr_store) begin
      snr_q[sel_q] <= zero_q ? 16'd0 : (sat_q ? 16'hFFFF : root_q);
    end
  end

  // Averages and the pulse decision feed the output register.
  logic [17:0] snr_sum, thr3, hpk_sum, vpk_sum;

  assign snr_sum = 18'(snr_q[0]) + 18'(snr_q[1]) + 18'(snr_q[2]);
  assign thr3    = 18'({thr_q, 1'b0}) + 18'(thr_q);
  assign hpk_sum = 18'(peak_q[0]) + 18'(peak_q[2]) + 18'(peak_q[4]);
  assign vpk_sum = 18'(peak_q[1]) + 18'(peak_q[3]) + 18'(peak_q[5]);

  logic out_valid_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.is_pulse   <= (snr_sum > thr3);
      out_q.h_snr_avg  <= div3(snr_sum);
      out_q.h_peak_avg <= div3(hpk_sum);
      out_q.v_peak_avg <= div3(vpk_sum);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller.
  assign sts_o.pass_end  = (rd_addr_q == cnt_q);
  assign sts_o.pipe_busy = rd_v1_q | sq_v_q;
  assign sts_o.special   = zero_q | sat_q;
  assign sts_o.div_last  = (step_q == 5'd31);
  assign sts_o.sqrt_last = (step_q == 5'd15);
  assign sts_o.sel_last  = (sel_q == 2'd2);
  assign sts_o.out_busy  = out_valid_q & ~out_ready_i;

endmodule

FILE: hw/rtl/multichannel_peak_snr_trigger.sv
// Loading: one sample request per cycle, accepted whenever the block is idle.
// Closing request: an energy pass over the N stored samples, then each horizontal
// channel in turn through the shared 32-step divider and 16-step root unit.
// No new request is accepted while a closed record is evaluated.
// Reset (async, active low) clears peaks, count and handshakes; memory is not cleared.
module multichannel_peak_snr_trigger import mpst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Control sequencer.
  mpst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_sample),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  mpst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/mpst_checker.sv
`include "assert_macros.svh"

module mpst_checker import mpst_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [CFG_W-1:0]     cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input in_t                  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_t                 out_data_o
);

  // A waiting result stays offered.
  `MPST_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // A waiting result keeps its value.
  `MPST_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o))

  // Closing a record stops intake while the record is evaluated.
  `MPST_ASSERT_NEXT(a_close_busy, in_valid_i && in_ready_o && in_data_i.last_sample,
                    !in_ready_o)

  // A new result only follows evaluation, never a cycle of intake.
  `MPST_ASSERT_IMP(a_out_after_eval, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind multichannel_peak_snr_trigger mpst_checker u_mpst_checker (.*);

FILE: verif/testbench.sv
module testbench;
  import mpst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REC   = 2048;
  localparam int TAIL_CYC  = 2600;
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam logic [41:0] ENERGY_SAT = {42{1'b1}};

  // Trigger prediction: record store, peaks, settings and pending results.
  class trigger_scoreboard;
    logic signed [15:0] samples[MAX_REC][8];
    logic [15:0] peak_mag[8];
    logic [10:0] peak_pos[8];
    int unsigned count;
    logic [15:0] thr;
    logic [9:0]  guard;
    logic [11:0] rms_div;
    out_t pending[$];
    int errors;

    function void clear();
      for (int c = 0; c < 8; c++) begin
        peak_mag[c] = '0;
        peak_pos[c] = '0;
      end
      count = 0;
      thr = 16'd384;
      guard = 10'd50;
      rms_div = 12'd1400;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SNR_THR: thr = val;
        REG_GUARD:   guard = val[9:0];
        REG_RMS_DIV: rms_div = val[11:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [15:0] snr_of(int c, logic [41:0] e);
      logic [63:0] pk;
      logic [63:0] s;
      pk = peak_mag[c];
      if (pk == 0 || rms_div == 0) return 16'd0;
      if (e == 0) return 16'hFFFF;
      s = int_sqrt((pk * pk * 64'd65536 * 64'(rms_div)) / 64'(e));
      return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function void note_request(in_t req);
      logic signed [15:0] v[8];
      logic [15:0] mag;
      logic [41:0] energy;
      logic [63:0] sum;
      logic [63:0] sq;
      logic [17:0] snr_sum;
      int unsigned d;
      out_t res;
      v = '{req.sample_h1, req.sample_v1, req.sample_h2, req.sample_v2,
            req.sample_h3, req.sample_v3, req.sample_h4, req.sample_v4};
      if (count < MAX_REC) begin
        for (int c = 0; c < 8; c++) begin
          samples[count][c] = v[c];
          mag = v[c][15] ? 16'(-v[c]) : v[c];
          if (mag > peak_mag[c]) begin
            peak_mag[c] = mag;
            peak_pos[c] = count[10:0];
          end
        end
        count++;
      end
      if (!req.last_sample) return;
      snr_sum = 0;
      for (int c = 0; c <= 4; c += 2) begin
        sum = 0;
        for (int i = 0; i < count; i++) begin
          d = (i > peak_pos[c]) ? i - peak_pos[c] : peak_pos[c] - i;
          if (d > guard) begin
            sq = 64'(longint'(samples[i][c]) * longint'(samples[i][c]));
            sum += sq;
            if (sum > ENERGY_SAT) sum = ENERGY_SAT;
          end
        end
        energy = sum[41:0];
        snr_sum += snr_of(c, energy);
      end
      res.is_pulse = (snr_sum > 3 * 18'(thr));
      res.h_snr_avg = 16'(snr_sum / 3);
      res.h_peak_avg = 16'((18'(peak_mag[0]) + peak_mag[2] + peak_mag[4]) / 3);
      res.v_peak_avg = 16'((18'(peak_mag[1]) + peak_mag[3] + peak_mag[5]) / 3);
      pending.push_back(res);
      for (int c = 0; c < 8; c++) begin
        peak_mag[c] = '0;
        peak_pos[c] = '0;
      end
      count = 0;
    endfunction

    function void check_result(out_t got);
      out_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.is_pulse !== exp_res.is_pulse) begin
        $error("is_pulse: expected %0d, actual %0d", exp_res.is_pulse, got.is_pulse);
        errors++;
      end
      if (got.h_snr_avg !== exp_res.h_snr_avg) begin
        $error("h_snr_avg: expected %0d, actual %0d", exp_res.h_snr_avg, got.h_snr_avg);
        errors++;
      end
      if (got.h_peak_avg !== exp_res.h_peak_avg) begin
        $error("h_peak_avg: expected %0d, actual %0d", exp_res.h_peak_avg,
               got.h_peak_avg);
        errors++;
      end
      if (got.v_peak_avg !== exp_res.v_peak_avg) begin
        $error("v_peak_avg: expected %0d, actual %0d", exp_res.v_peak_avg,
               got.v_peak_avg);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  trigger_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  longint cycles;

  multichannel_peak_snr_trigger u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, optional long hold-off, check on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One register write; the enable drops before the next write starts.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Offers one request; valid stays up afterwards until the next request
  // or an idle cycle replaces it.
  task automatic send_request(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64) - 32);
      default: return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  // One record of n items; noise samples with an optional pulse spike.
  task automatic send_record(int n, int mode, bit spike);
    in_t req;
    int spot;
    spot = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      req.sample_h1 = rand_sample(mode);
      req.sample_v1 = rand_sample(mode);
      req.sample_h2 = rand_sample(mode);
      req.sample_v2 = rand_sample(mode);
      req.sample_h3 = rand_sample(mode);
      req.sample_v3 = rand_sample(mode);
      req.sample_h4 = rand_sample(mode);
      req.sample_v4 = rand_sample(mode);
      if (spike && i == spot) begin
        req.sample_h1 = 16'($urandom_range(2000, 32767));
        req.sample_h2 = -16'($urandom_range(2000, 32767));
        req.sample_h3 = 16'($urandom_range(2000, 32767));
        req.sample_v2 = 16'h8000;
      end
      req.last_sample = (i == n - 1);
      send_request(req);
    end
  endtask

  task automatic random_records(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(1, 12);
      send_record(n, $urandom_range(9) < 7 ? 1 : ($urandom_range(1) ? 0 : 2),
                  $urandom_range(1));
      sent += n;
    end
  endtask

  initial begin
    in_t req;
    sb = new();
    sb.clear();
    cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SNR_THR;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-item records of all zeros and at the extremes, then records with equal peaks.
    req = '{default: '0};
    req.last_sample = 1'b1;
    send_request(req);
    req = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
           16'h8000, 16'h7FFF, 1'b1};
    send_request(req);
    req.last_sample = 1'b0;
    send_request(req);
    send_request(req);
    req = {16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h0000, 16'h7FFE,
           16'h8001, 16'h1234, 1'b1};
    send_request(req);
    send_record(20, 2, 1'b0);
    drain();

    // Extreme settings: zero divisor and guard, then widest guard, then full divisor.
    write_reg(REG_RMS_DIV, 16'd0);
    write_reg(REG_GUARD, 16'd0);
    write_reg(REG_SNR_THR, 16'd0);
    send_record(6, 0, 1'b1);
    drain();
    write_reg(REG_RMS_DIV, 16'd2048);
    write_reg(REG_GUARD, 16'd1023);
    write_reg(REG_SNR_THR, 16'hFFFF);
    send_record(5, 1, 1'b1);
    drain();
    write_reg(REG_RMS_DIV, 16'd4095);
    write_reg(REG_GUARD, 16'd1);
    write_reg(REG_SNR_THR, 16'd384);
    send_record(9, 1, 1'b1);
    drain();

    // Overflowing record: excess items and the dropped closing item.
    write_reg(REG_GUARD, 16'd3);
    write_reg(REG_RMS_DIV, 16'd1);
    send_record(MAX_REC + 2, 2, 1'b1);
    drain();

    // Random phase one: sender idles lightly, receiver heavily.
    write_reg(REG_GUARD, 16'd2);
    write_reg(REG_RMS_DIV, 16'd1400);
    write_reg(REG_SNR_THR, 16'd600);
    send_idle_pct = 16;
    recv_idle_pct = 51;
    random_records(180);
    drain();

    // Long receiver hold-off while requests keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_records(30);
    join
    drain();

    // Random phase two: swapped idling, new settings.
    write_reg(REG_GUARD, 16'($urandom_range(0, 8)));
    write_reg(REG_RMS_DIV, 16'($urandom_range(1, 2048)));
    write_reg(REG_SNR_THR, 16'($urandom_range(0, 2000)));
    send_idle_pct = 51;
    recv_idle_pct = 16;
    random_records(170);
    drain();

    // Random phase three: no idling.
    write_reg(REG_GUARD, 16'd50);
    write_reg(REG_RMS_DIV, 16'd1400);
    write_reg(REG_SNR_THR, 16'd384);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_records(170);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
